@@ rtl/core/otfc_pkg.sv @@
package otfc_pkg;

	// config port
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 9;

	localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH         = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT        = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_TILE_SIZE          = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_FOOTPRINT_SIZE     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_OCCUPIED_THRESHOLD = 3'd4;

	// item kinds
	localparam logic FUNC_LOAD  = 1'b0;
	localparam logic FUNC_QUERY = 1'b1;

	// stream widths
	localparam int S_TDATA_W = 40;
	localparam int M_TDATA_W = 8;

	// tile origin in cells: 8-bit tile index times 5-bit tile size
	localparam int ORG_W = 13;

	typedef struct packed {
		logic [8:0] grid_width;
		logic [8:0] grid_height;
		logic [4:0] tile_size;
		logic [4:0] footprint_size;
		logic [6:0] occupied_threshold;
	} cfg_t;

	typedef struct packed {
		logic              func;
		logic [7:0]        cell_row;
		logic [7:0]        cell_col;
		logic signed [7:0] cell_value;
		logic [7:0]        tile_row;
		logic [7:0]        tile_col;
	} item_t;

	typedef struct packed {
		logic tile_blocked;
		logic status;
	} res_t;

endpackage

@@ rtl/core/occupancy_tile_footprint_check.sv @@
// Occupancy tile footprint check. Load words (tuser 0) write one blocked bit
// into an internal map RAM at row*W+col and return nothing; a load outside
// the current grid is dropped. Query words (tuser 1) take the tile origin
// (tile_row*T, tile_col*T), shift it back by ceil((F-T)/2) (0 when F<T), and
// walk the F-by-F window clipped at the grid edge, one RAM read per cycle,
// row by row, stopping at the first blocked cell, so a query ends early when
// a blocked cell turns up; it skips the walk when the tile origin is off the
// map. No new word is taken while a query is in flight. The single RAM read
// port sets that pace. The map has no reset: read only cells already loaded.
// One result word per query, held in an output register, so loads keep
// flowing while it waits. Config writes (always ready) belong in idle periods
// only; W and H saturate to 1..MAX, T of 0 acts as 1.
module occupancy_tile_footprint_check import otfc_pkg::*; #(
	parameter int MAX_WIDTH     = 256,
	parameter int MAX_HEIGHT    = 256,
	parameter int MAX_FOOTPRINT = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// config write channel
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	// input stream
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [S_TDATA_W-1:0]  s_tdata,  // cell_row, cell_col, cell_value, tile_row, tile_col
	input  logic                  s_tuser,  // func
	// result stream
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [M_TDATA_W-1:0]  m_tdata,  // tile_blocked, zero pad
	output logic                  m_tuser   // status
);

	localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
	localparam int AW    = DEPTH > 1 ? $clog2(DEPTH) : 1;

	cfg_t          cfg_q;
	item_t         in_item;
	res_t          res, out_q;
	logic          res_valid, res_ready;
	logic          m_tvalid_q;
	logic          mem_we, mem_wdata, mem_rdata;
	logic [AW-1:0] mem_waddr, mem_raddr;

	// config registers, unknown index dropped
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '{grid_width: 9'd256, grid_height: 9'd256, tile_size: 5'd1,
			           footprint_size: 5'd1, occupied_threshold: 7'd65};
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_GRID_WIDTH:         cfg_q.grid_width         <= cfg_data;
				REG_GRID_HEIGHT:        cfg_q.grid_height        <= cfg_data;
				REG_TILE_SIZE:          cfg_q.tile_size          <= cfg_data[4:0];
				REG_FOOTPRINT_SIZE:     cfg_q.footprint_size     <= cfg_data[4:0];
				REG_OCCUPIED_THRESHOLD: cfg_q.occupied_threshold <= cfg_data[6:0];
				default: ;
			endcase
		end
	end

	// input word unpack
	assign in_item.func       = s_tuser;
	assign in_item.cell_row   = s_tdata[7:0];
	assign in_item.cell_col   = s_tdata[15:8];
	assign in_item.cell_value = $signed(s_tdata[23:16]);
	assign in_item.tile_row   = s_tdata[31:24];
	assign in_item.tile_col   = s_tdata[39:32];

	otfc_ctrl #(
		.MAX_WIDTH     (MAX_WIDTH),
		.MAX_HEIGHT    (MAX_HEIGHT),
		.MAX_FOOTPRINT (MAX_FOOTPRINT)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_item   (in_item),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res),
		.mem_we    (mem_we),
		.mem_waddr (mem_waddr),
		.mem_wdata (mem_wdata),
		.mem_raddr (mem_raddr),
		.mem_rdata (mem_rdata)
	);

	otfc_ram #(
		.WIDTH (1),
		.DEPTH (DEPTH)
	) u_map (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	// output register decouples the scan from the result consumer
	assign res_ready = !m_tvalid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (res_valid && res_ready) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			out_q <= res;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {(M_TDATA_W-1)'(0), out_q.tile_blocked};
	assign m_tuser  = out_q.status;

endmodule

@@ rtl/core/otfc_ram.sv @@
module otfc_ram #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 65536
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

@@ rtl/core/otfc_ctrl.sv @@
module otfc_ctrl import otfc_pkg::*; #(
	parameter int MAX_WIDTH     = 256,
	parameter int MAX_HEIGHT    = 256,
	parameter int MAX_FOOTPRINT = 16
) (
	input  logic                                                   clk,
	input  logic                                                   arst_n,
	input  cfg_t                                                   cfg,
	input  logic                                                   in_valid,
	output logic                                                   in_ready,
	input  item_t                                                  in_item,
	output logic                                                   res_valid,
	input  logic                                                   res_ready,
	output res_t                                                   res,
	output logic                                                   mem_we,
	output logic [(MAX_WIDTH*MAX_HEIGHT > 1 ? $clog2(MAX_WIDTH*MAX_HEIGHT) : 1)-1:0] mem_waddr,
	output logic                                                   mem_wdata,
	output logic [(MAX_WIDTH*MAX_HEIGHT > 1 ? $clog2(MAX_WIDTH*MAX_HEIGHT) : 1)-1:0] mem_raddr,
	input  logic                                                   mem_rdata
);

	localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
	localparam int AW    = DEPTH > 1 ? $clog2(DEPTH) : 1;
	localparam int WW    = $clog2(MAX_WIDTH + 1);
	localparam int HW    = $clog2(MAX_HEIGHT + 1);
	localparam int FW    = $clog2(MAX_FOOTPRINT + 1);
	// signed linear index, covers the window hanging off the top-left corner
	localparam int SW    =
		$clog2((MAX_HEIGHT + MAX_FOOTPRINT + 1) * (MAX_WIDTH + MAX_FOOTPRINT + 1)) + 2;

	typedef enum logic [5:0] {
		S_IDLE  = 6'b000001,
		S_ORG   = 6'b000010,
		S_BASE  = 6'b000100,
		S_SCAN  = 6'b001000,
		S_DRAIN = 6'b010000,
		S_DONE  = 6'b100000
	} state_t;

	state_t               state_q;
	logic [ORG_W-1:0]     oy_q, ox_q;
	logic [FW-1:0]        rows_n_q, cols_n_q;
	logic [FW-1:0]        r_q, c_q;
	logic signed [SW-1:0] roff_q, coff_q;
	logic signed [SW-1:0] line_q, cur_q;
	logic                 rd_vld_s1;
	res_t                 res_q;

	logic [WW-1:0] w_c;
	logic [HW-1:0] h_c;
	logic [4:0]    t_c;
	logic [FW-1:0] f_c;
	logic [FW-1:0] off_c;
	logic          found;
	logic [31:0]   h_left, w_left;

	// saturated register values
	always_comb begin
		if (cfg.grid_width == '0) begin
			w_c = WW'(1);
		end else if (32'(cfg.grid_width) > MAX_WIDTH) begin
			w_c = WW'(MAX_WIDTH);
		end else begin
			w_c = WW'(cfg.grid_width);
		end
		if (cfg.grid_height == '0) begin
			h_c = HW'(1);
		end else if (32'(cfg.grid_height) > MAX_HEIGHT) begin
			h_c = HW'(MAX_HEIGHT);
		end else begin
			h_c = HW'(cfg.grid_height);
		end
		t_c = (cfg.tile_size == '0) ? 5'd1 : cfg.tile_size;
		if (cfg.footprint_size == '0) begin
			f_c = FW'(1);
		end else if (32'(cfg.footprint_size) > MAX_FOOTPRINT) begin
			f_c = FW'(MAX_FOOTPRINT);
		end else begin
			f_c = FW'(cfg.footprint_size);
		end
		if (32'(f_c) >= 32'(t_c)) begin
			off_c = FW'((32'(f_c) - 32'(t_c) + 32'd1) >> 1);
		end else begin
			off_c = '0;
		end
	end

	assign h_left = 32'(h_c) - 32'(oy_q);
	assign w_left = 32'(w_c) - 32'(ox_q);

	// cell load: one write, no result
	assign in_ready  = (state_q == S_IDLE);
	assign mem_we    = in_valid && in_ready && (in_item.func == FUNC_LOAD)
	                   && (32'(in_item.cell_row) < 32'(h_c))
	                   && (32'(in_item.cell_col) < 32'(w_c));
	assign mem_waddr = AW'(32'(in_item.cell_row) * 32'(w_c) + 32'(in_item.cell_col));
	assign mem_wdata = in_item.cell_value[7]
	                   | (in_item.cell_value[6:0] > cfg.occupied_threshold);

	// negative index clamps to cell 0
	assign mem_raddr = cur_q[SW-1] ? '0 : cur_q[AW-1:0];
	assign found     = rd_vld_s1 && mem_rdata;

	assign res_valid = (state_q == S_DONE);
	assign res       = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			rd_vld_s1 <= 1'b0;
		end else begin
			rd_vld_s1 <= (state_q == S_SCAN) && !found;
			case (state_q)
				S_IDLE: begin
					if (in_valid && in_item.func == FUNC_QUERY) begin
						oy_q    <= ORG_W'(16'(in_item.tile_row) * 16'(t_c));
						ox_q    <= ORG_W'(16'(in_item.tile_col) * 16'(t_c));
						state_q <= S_ORG;
					end
				end
				S_ORG: begin
					if (32'(oy_q) >= 32'(h_c) || 32'(ox_q) >= 32'(w_c)) begin
						res_q   <= '{tile_blocked: 1'b0, status: 1'b1};
						state_q <= S_DONE;
					end else begin
						rows_n_q <= (h_left < 32'(f_c)) ? FW'(h_left) : f_c;
						cols_n_q <= (w_left < 32'(f_c)) ? FW'(w_left) : f_c;
						roff_q   <= $signed(SW'(oy_q)) - $signed(SW'(off_c));
						coff_q   <= $signed(SW'(ox_q)) - $signed(SW'(off_c));
						state_q  <= S_BASE;
					end
				end
				S_BASE: begin
					line_q  <= roff_q * $signed(SW'(w_c)) + coff_q;
					cur_q   <= roff_q * $signed(SW'(w_c)) + coff_q;
					r_q     <= '0;
					c_q     <= '0;
					state_q <= S_SCAN;
				end
				S_SCAN: begin
					if (found) begin
						res_q   <= '{tile_blocked: 1'b1, status: 1'b0};
						state_q <= S_DONE;
					end else if (c_q == cols_n_q - FW'(1)) begin
						if (r_q == rows_n_q - FW'(1)) begin
							state_q <= S_DRAIN;
						end else begin
							r_q    <= r_q + FW'(1);
							c_q    <= '0;
							line_q <= line_q + $signed(SW'(w_c));
							cur_q  <= line_q + $signed(SW'(w_c));
						end
					end else begin
						c_q   <= c_q + FW'(1);
						cur_q <= cur_q + SW'(1);
					end
				end
				S_DRAIN: begin
					res_q   <= '{tile_blocked: mem_rdata, status: 1'b0};
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (res_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

`ifndef ASSERT_OFF
	a_write_idle: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> state_q == S_IDLE)
		else $error("map write outside idle");

	a_read_from_scan: assert property (@(posedge clk) disable iff (!arst_n)
		rd_vld_s1 |-> $past(state_q == S_SCAN))
		else $error("read data flagged without a scan read");

	a_scan_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_SCAN |-> (c_q < cols_n_q) && (r_q < rows_n_q))
		else $error("window counter past clipped edge");

	a_outside_clear: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.status |-> !res.tile_blocked)
		else $error("outside tile reported blocked");
`endif

endmodule

@@ tb/tb_occupancy_tile_footprint_check.sv @@
`timescale 1ns / 1ps

module tb_occupancy_tile_footprint_check import otfc_pkg::*; ();

	localparam int MAX_W        = 256;
	localparam int MAX_H        = 256;
	localparam int MAX_F        = 16;
	// a query walks at most 16x16 cells plus its overhead
	localparam int SETTLE_CYCLES = 300;
	localparam int CYCLE_LIMIT   = 2_000_000;
	localparam int IDLE_PCT      = 37;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [S_TDATA_W-1:0]  s_tdata;   // cell_row, cell_col, cell_value, tile_row, tile_col
	logic                  s_tuser;   // func
	logic                  m_tvalid;
	logic                  m_tready;
	logic [M_TDATA_W-1:0]  m_tdata;   // tile_blocked, zero pad
	logic                  m_tuser;   // status

	// shadow copy of the config registers, raw as written
	logic [8:0] width_reg;
	logic [8:0] height_reg;
	logic [4:0] tile_reg;
	logic [4:0] foot_reg;
	logic [6:0] thr_reg;

	// blocked bit per cell, linear address row*W + col
	bit   blocked_cells [0:MAX_W*MAX_H-1];
	res_t pending_answers [$];

	int  fail_count;
	int  cycle_count;
	bit  pace_gaps;   // random idling on both sides when set

	occupancy_tile_footprint_check dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always begin
		clk = 1'b1;
		#1;
		clk = 1'b0;
		#1;
	end

	// ---------------------------------------------------------------
	// effective register values: W/H saturate, T of 0 is 1, F saturates
	// ---------------------------------------------------------------
	function automatic int grid_w();
		return (width_reg == 0) ? 1 : ((width_reg > MAX_W) ? MAX_W : int'(width_reg));
	endfunction

	function automatic int grid_h();
		return (height_reg == 0) ? 1 : ((height_reg > MAX_H) ? MAX_H : int'(height_reg));
	endfunction

	function automatic int tile_edge();
		return (tile_reg == 0) ? 1 : int'(tile_reg);
	endfunction

	function automatic int foot_edge();
		return (foot_reg == 0) ? 1 : ((foot_reg > MAX_F) ? MAX_F : int'(foot_reg));
	endfunction

	// answer of one tile query against the current map and registers
	function automatic res_t predict_tile_answer(logic [7:0] trow, logic [7:0] tcol);
		int   w, h, t, f, oy, ox, off, idx, r, c;
		res_t ans;
		w = grid_w();
		h = grid_h();
		t = tile_edge();
		f = foot_edge();
		oy = int'(trow) * t;
		ox = int'(tcol) * t;
		// window shifted back by ceil((F-T)/2); no shift for small footprints
		off = (f >= t) ? (f - t + 1) / 2 : 0;
		ans.tile_blocked = 1'b0;
		ans.status       = 1'b0;
		if (oy >= h || ox >= w) begin
			ans.status = 1'b1;
			return ans;
		end
		for (r = 0; r < f && oy + r < h; r++) begin
			for (c = 0; c < f && ox + c < w; c++) begin
				// a negative column offset wraps into the row above
				idx = (oy + r - off) * w + (ox + c - off);
				if (idx < 0)
					idx = 0;
				if (blocked_cells[idx])
					ans.tile_blocked = 1'b1;
			end
		end
		return ans;
	endfunction

	// update map or queue an answer for one accepted word
	function automatic void track_word(item_t it);
		int v;
		if (it.func == FUNC_LOAD) begin
			v = int'(it.cell_value);
			// loads off the current grid are dropped
			if (int'(it.cell_row) < grid_h() && int'(it.cell_col) < grid_w())
				blocked_cells[int'(it.cell_row) * grid_w() + int'(it.cell_col)] =
					(v < 0) || (v > int'(thr_reg));
		end else begin
			pending_answers = {pending_answers,
				predict_tile_answer(it.tile_row, it.tile_col)};
		end
	endfunction

	// ---------------------------------------------------------------
	// word builders
	// ---------------------------------------------------------------
	function automatic item_t load_word(int row, int col, logic signed [7:0] val);
		item_t it;
		it.func       = FUNC_LOAD;
		it.cell_row   = row[7:0];
		it.cell_col   = col[7:0];
		it.cell_value = val;
		it.tile_row   = 8'($urandom_range(0, 255));
		it.tile_col   = 8'($urandom_range(0, 255));
		return it;
	endfunction

	function automatic item_t query_word(int trow, int tcol);
		item_t it;
		it.func       = FUNC_QUERY;
		it.cell_row   = 8'($urandom_range(0, 255));
		it.cell_col   = 8'($urandom_range(0, 255));
		it.cell_value = 8'($urandom_range(0, 255));
		it.tile_row   = trow[7:0];
		it.tile_col   = tcol[7:0];
		return it;
	endfunction

	// cell value, blocked with the given chance (negative or above threshold)
	function automatic logic signed [7:0] pick_cell_value(int blocked_pct);
		int v;
		if ($urandom_range(0, 99) < blocked_pct) begin
			if (thr_reg == 7'd127 || $urandom_range(0, 1))
				v = int'($urandom_range(0, 127)) - 128;
			else
				v = $urandom_range(int'(thr_reg) + 1, 127);
		end else begin
			v = $urandom_range(0, int'(thr_reg));
		end
		return v[7:0];
	endfunction

	// ---------------------------------------------------------------
	// bus drivers
	// ---------------------------------------------------------------
	task automatic send_word(item_t it);
		if (pace_gaps && $urandom_range(0, 99) < IDLE_PCT) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(0, 3) == 0 ? $urandom_range(2, 5) : 1) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= it.func;
		s_tdata  <= {it.tile_col, it.tile_row, it.cell_value, it.cell_col, it.cell_row};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		track_word(it);
	endtask

	// block idle: no answer outstanding and the last walk long finished
	task automatic wait_idle();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending_answers.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		case (idx)
			REG_GRID_WIDTH:         width_reg  = data;
			REG_GRID_HEIGHT:        height_reg = data;
			REG_TILE_SIZE:          tile_reg   = data[4:0];
			REG_FOOTPRINT_SIZE:     foot_reg   = data[4:0];
			REG_OCCUPIED_THRESHOLD: thr_reg    = data[6:0];
			default: ;
		endcase
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_grid(int w, int h, int t, int f, int thr);
		write_reg(REG_GRID_WIDTH, w[8:0]);
		write_reg(REG_GRID_HEIGHT, h[8:0]);
		write_reg(REG_TILE_SIZE, t[8:0]);
		write_reg(REG_FOOTPRINT_SIZE, f[8:0]);
		write_reg(REG_OCCUPIED_THRESHOLD, thr[8:0]);
	endtask

	// write every cell of the current grid so no query touches an unwritten cell
	task automatic preload_grid(int blocked_pct);
		int r, c;
		for (r = 0; r < grid_h(); r++)
			for (c = 0; c < grid_w(); c++)
				send_word(load_word(r, c, pick_cell_value(blocked_pct)));
	endtask

	// ---------------------------------------------------------------
	// result side: random back-pressure and in-order compare
	// ---------------------------------------------------------------
	always @(posedge clk) begin
		res_t exp_ans;
		if (m_tvalid && m_tready) begin
			if (pending_answers.size() == 0) begin
				$error("result word with no query outstanding: tdata %h tuser %b",
					m_tdata, m_tuser);
				fail_count++;
			end else begin
				exp_ans = pending_answers.pop_front();
				if (m_tdata[0] !== exp_ans.tile_blocked) begin
					$error("tile_blocked: expected %0b, got %0b", exp_ans.tile_blocked,
						m_tdata[0]);
					fail_count++;
				end
				if (m_tuser !== exp_ans.status) begin
					$error("status: expected %0b, got %0b", exp_ans.status, m_tuser);
					fail_count++;
				end
				if (m_tdata[M_TDATA_W-1:1] !== '0) begin
					$error("tdata pad: expected 0, got %h", m_tdata[M_TDATA_W-1:1]);
					fail_count++;
				end
			end
		end
		m_tready <= !(pace_gaps && $urandom_range(0, 99) < IDLE_PCT);
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	// ---------------------------------------------------------------
	// tests
	// ---------------------------------------------------------------

	// small 4x3 map: threshold edges, unknown cells, dropped loads,
	// tiles off the map, clamp at index 0 and wrap into the row above
	task automatic test_load_and_query();
		set_grid(4, 3, 2, 3, 65);
		preload_grid(0);
		send_word(load_word(0, 0, 8'sd65));     // equal to threshold: free
		send_word(load_word(0, 1, 8'sd66));     // just above: blocked
		send_word(query_word(0, 0));
		send_word(load_word(0, 1, 8'sd0));
		send_word(query_word(0, 0));
		send_word(load_word(1, 0, -8'sd1));     // unknown
		send_word(load_word(2, 3, 8'sd127));
		send_word(load_word(3, 0, -8'sd128));   // row off the map
		send_word(load_word(0, 4, -8'sd1));     // column off the map
		send_word(load_word(255, 255, -8'sd1));
		send_word(query_word(0, 1));            // row offset below 0: reads clamp to cell 0
		send_word(query_word(1, 1));
		send_word(query_word(1, 0));
		send_word(query_word(2, 0));            // origin row 4 >= H
		send_word(query_word(0, 2));            // origin col 4 >= W
		send_word(query_word(255, 255));
		send_word(load_word(1, 0, 8'sd100));
		send_word(load_word(2, 3, 8'sd0));
		send_word(query_word(1, 1));
		wait_idle();
		// footprint smaller than tile: no shift
		write_reg(REG_FOOTPRINT_SIZE, 9'd1);
		send_word(query_word(0, 0));
		send_word(query_word(1, 0));
		send_word(query_word(1, 1));
		wait_idle();
	endtask

	// values outside the register ranges, spare indexes, junk upper bits
	task automatic test_register_limits();
		int i;
		// zero width/height/tile/footprint all act as 1
		set_grid(0, 0, 0, 0, 0);
		send_word(load_word(0, 0, 8'sd1));
		send_word(load_word(0, 1, 8'sd0));      // dropped
		send_word(query_word(0, 0));
		send_word(query_word(0, 1));
		send_word(query_word(1, 0));
		send_word(load_word(0, 0, 8'sd0));
		send_word(query_word(0, 0));
		wait_idle();
		// oversize width saturates, huge tile, oversize footprint saturates
		set_grid(511, 1, 31, 31, 127);
		// cells under the first and the last tile of the row
		for (i = 0; i < 16; i++)
			send_word(load_word(0, i, pick_cell_value(8)));
		for (i = 248; i < 256; i++)
			send_word(load_word(0, i, pick_cell_value(8)));
		send_word(query_word(0, 0));
		send_word(query_word(0, 8));            // origin col 248, clipped at col 255
		send_word(query_word(0, 9));            // origin col 279 >= W
		send_word(query_word(1, 0));
		wait_idle();
		// spare indexes must not disturb anything
		for (i = int'(REG_OCCUPIED_THRESHOLD) + 1; i < 2**CFG_IDX_W; i++)
			write_reg(i[CFG_IDX_W-1:0], 9'($urandom_range(0, 511)));
		// tile size from the low 5 bits only: 3
		write_reg(REG_TILE_SIZE, 9'h1E3);
		write_reg(REG_FOOTPRINT_SIZE, 9'd16);
		for (i = 0; i < 8; i++)
			send_word(query_word(0, $urandom_range(0, 90)));
		wait_idle();
	endtask

	// one-row and one-column maps at full size
	task automatic test_map_extremes();
		int i;
		set_grid(1, 256, 16, 16, 100);
		// only the first and the last tile rows are walked
		for (i = 0; i < 16; i++) begin
			send_word(load_word(i, 0, pick_cell_value(10)));
			send_word(load_word(240 + i, 0, pick_cell_value(10)));
		end
		send_word(query_word(0, 0));
		send_word(query_word(15, 0));
		send_word(query_word(16, 0));           // origin row 256 >= H
		send_word(query_word(0, 1));
		wait_idle();
		// row 0 now holds cells 0..15 and 240..255
		set_grid(256, 256, 16, 1, 100);
		send_word(query_word(0, 0));
		send_word(query_word(0, 15));
		send_word(query_word(16, 0));
		send_word(query_word(0, 16));
		send_word(query_word(255, 255));
		wait_idle();
		// window hangs off the top-left corner: every read clamps to cell 0
		set_grid(256, 1, 1, 16, 50);
		for (i = 0; i < 6; i++) begin
			if (i % 3 == 0)
				send_word(load_word(0, 0, pick_cell_value(50)));
			send_word(query_word(0, $urandom_range(0, 255)));
		end
		send_word(query_word(0, 255));
		send_word(query_word(1, 0));
		wait_idle();
	endtask

	// random grids and mixed traffic; the first phase runs with no idling
	task automatic test_random_traffic();
		int ph, n, k, w, h, t, f, thr, pct, span_r, span_c;
		for (ph = 0; ph < 5; ph++) begin
			k = $urandom_range(0, 9);
			w = (k == 0) ? 1 : ((k == 1) ? $urandom_range(17, 40) : $urandom_range(2, 16));
			h = $urandom_range(1, 48 / w);
			if ($urandom_range(0, 9) == 0)
				h = 1;
			k = $urandom_range(0, 19);
			t = (k == 0) ? 0 : (k == 1) ? $urandom_range(17, 31) :
				(k < 4) ? $urandom_range(9, 16) : $urandom_range(1, 8);
			k = $urandom_range(0, 19);
			f = (k == 0) ? 0 : (k == 1) ? $urandom_range(17, 31) : $urandom_range(1, 16);
			thr = ($urandom_range(0, 9) == 0) ? $urandom_range(101, 127) : $urandom_range(0, 100);
			pace_gaps = 1'b0;
			set_grid(w, h, t, f, thr);
			k = $urandom_range(0, 2);
			pct = (k == 0) ? 1 : ((k == 1) ? 5 : 20);
			pace_gaps = (ph != 0);
			preload_grid(pct);
			span_r = (grid_h() - 1) / tile_edge() + 1;
			span_c = (grid_w() - 1) / tile_edge() + 1;
			for (n = 0; n < 30; n++) begin
				k = $urandom_range(0, 99);
				if (k < 30)
					send_word(load_word($urandom_range(0, grid_h() - 1),
						$urandom_range(0, grid_w() - 1), pick_cell_value(pct)));
				else if (k < 38)
					send_word(load_word($urandom_range(0, 255), $urandom_range(0, 255),
						8'($urandom_range(0, 255))));
				else if (k < 88)
					send_word(query_word($urandom_range(0, span_r > 255 ? 255 : span_r),
						$urandom_range(0, span_c > 255 ? 255 : span_c)));
				else
					send_word(query_word($urandom_range(0, 255), $urandom_range(0, 255)));
			end
			wait_idle();
		end
	endtask

	initial begin
		arst_n     = 1'b0;
		cfg_valid  = 1'b0;
		cfg_index  = '0;
		cfg_data   = '0;
		s_tvalid   = 1'b0;
		s_tdata    = '0;
		s_tuser    = FUNC_LOAD;
		m_tready   = 1'b0;
		fail_count = 0;
		cycle_count = 0;
		pace_gaps  = 1'b1;
		// reset values of the registers
		width_reg  = 9'd256;
		height_reg = 9'd256;
		tile_reg   = 5'd1;
		foot_reg   = 5'd1;
		thr_reg    = 7'd65;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		test_load_and_query();
		test_register_limits();
		test_map_extremes();
		test_random_traffic();
		wait_idle();

		if (fail_count == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

@@ filelist.f @@
rtl/core/otfc_pkg.sv
rtl/core/otfc_ram.sv
rtl/core/otfc_ctrl.sv
rtl/core/occupancy_tile_footprint_check.sv
tb/tb_occupancy_tile_footprint_check.sv
